@@ rtl/dda_lr_pkg.sv @@
// shared types, constants and microcode program of the dda line rasterizer
package dda_lr_pkg;

  localparam int COORD_BITS    = 12;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_BITS      = 12;
  localparam int CFG_IDX_BITS  = 4;
  localparam int COLOR_BITS    = 32;
  localparam int PC_BITS       = 3;

  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(800);
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(600);

  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_HEIGHT = CFG_IDX_BITS'(1);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // program addresses
  localparam logic [PC_BITS-1:0] PC_WAIT    = 3'd0;
  localparam logic [PC_BITS-1:0] PC_SETUP   = 3'd1;
  localparam logic [PC_BITS-1:0] PC_XINIT   = 3'd2;
  localparam logic [PC_BITS-1:0] PC_XITER   = 3'd3;
  localparam logic [PC_BITS-1:0] PC_XSTORE  = 3'd4;
  localparam logic [PC_BITS-1:0] PC_YINIT   = 3'd5;
  localparam logic [PC_BITS-1:0] PC_YITER   = 3'd6;
  localparam logic [PC_BITS-1:0] PC_YSTORE  = 3'd7;

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_SETUP,
    OP_DIVX_INIT,
    OP_DIVY_INIT,
    OP_DIV_STEP,
    OP_STORE_X,
    OP_STORE_Y
  } op_e;

  // jump when the condition holds, else fall through to the next step
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_LOAD,
    COND_ZERO,
    COND_ITER
  } cond_e;

  typedef struct packed {
    op_e                op;
    cond_e              cond;
    logic [PC_BITS-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic                         cmd;
    logic signed [COORD_BITS-1:0] x_start;
    logic signed [COORD_BITS-1:0] y_start;
    logic signed [COORD_BITS-1:0] x_end;
    logic signed [COORD_BITS-1:0] y_end;
    logic [COLOR_BITS-1:0]        line_color;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0]        pixel_color;
    logic                         on_screen;
    logic                         last;
  } out_word_t;

  function automatic ucode_t ucode_rom(input logic [PC_BITS-1:0] pc);
    ucode_t w;
    unique case (pc)
      PC_WAIT:   w = '{op: OP_WAIT,      cond: COND_NO_LOAD, target: PC_WAIT};
      PC_SETUP:  w = '{op: OP_SETUP,     cond: COND_ZERO,    target: PC_WAIT};
      PC_XINIT:  w = '{op: OP_DIVX_INIT, cond: COND_NEVER,   target: PC_WAIT};
      PC_XITER:  w = '{op: OP_DIV_STEP,  cond: COND_ITER,    target: PC_XITER};
      PC_XSTORE: w = '{op: OP_STORE_X,   cond: COND_NEVER,   target: PC_WAIT};
      PC_YINIT:  w = '{op: OP_DIVY_INIT, cond: COND_NEVER,   target: PC_WAIT};
      PC_YITER:  w = '{op: OP_DIV_STEP,  cond: COND_ITER,    target: PC_YITER};
      PC_YSTORE: w = '{op: OP_STORE_Y,   cond: COND_ALWAYS,  target: PC_WAIT};
      default:   w = '{op: OP_WAIT,      cond: COND_ALWAYS,  target: PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/dda_line_rasterizer_unit.sv @@
// dda line rasterizer: microcoded load sequencer with shared divider and pixel stepper
// a step word's pixel is in the output register from the cycle after its acceptance
// throughput: step words are taken one per cycle while waiting and the output register drains
// a load runs the sequencer through these steps, only the setup step if zero length:
//   one setup step, then per axis an init, FRAC_BITS+1 restoring divide steps and a store
// reset: asynchronous active low, no line active, width 800, height 600, output empty
module dda_line_rasterizer_unit
  import dda_lr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  in_word_t                in_word_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output out_word_t               out_word_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [CFG_BITS-1:0]     cfg_data_i
);

  localparam int C         = COORD_BITS;
  localparam int POS_BITS  = C + FRAC_BITS + 1;
  localparam int INC_BITS  = FRAC_BITS + 2;
  localparam int LEFT_BITS = C + 1;
  localparam int NUM_BITS  = C + FRAC_BITS + 1;
  localparam int Q_BITS    = FRAC_BITS + 1;
  localparam int ITERS     = FRAC_BITS + 1;
  localparam int CNT_BITS  = $clog2(ITERS + 1);
  localparam int PX_BITS   = C + 2;

  // sequencer state
  logic [PC_BITS-1:0]  pc_q, pc_d;
  ucode_t              uw;
  logic                cond_hit;

  // configuration registers
  logic [CFG_BITS-1:0] width_q, height_q;

  // latched load word and setup results
  in_word_t            ld_q;
  logic [C-1:0]        mag_x_q, mag_y_q, steps_q;
  logic                neg_x_q, neg_y_q;

  // divider datapath
  logic [C-1:0]        rem_q, rem_d;
  logic [Q_BITS-1:0]   qn_q, qn_d;
  logic [CNT_BITS-1:0] cnt_q;

  // line state
  logic signed [POS_BITS-1:0] pos_x_q, pos_y_q;
  logic signed [INC_BITS-1:0] inc_x_q, inc_y_q;
  logic [LEFT_BITS-1:0]       left_q;
  logic [COLOR_BITS-1:0]      color_q;

  // output register
  logic                out_valid_q;
  out_word_t           out_q;

  logic in_fire, load_fire, step_fire, emit;

  // ---------------------------------------------------------------------------
  // handshakes: input is only taken on the wait step, and only while the output
  // register is empty or being drained in the same cycle
  // ---------------------------------------------------------------------------
  assign uw          = ucode_rom(pc_q);
  assign in_ready_o  = (uw.op == OP_WAIT) && (!out_valid_q || out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign load_fire   = in_fire && (in_word_i.cmd == CMD_LOAD);
  assign step_fire   = in_fire && (in_word_i.cmd == CMD_STEP);
  assign emit        = step_fire && (left_q != '0);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // ---------------------------------------------------------------------------
  // setup arithmetic on the latched endpoints
  // ---------------------------------------------------------------------------
  logic signed [C:0] dx_w, dy_w;
  logic [C:0]        nx_w, ny_w;
  logic [C-1:0]      mag_x_w, mag_y_w, steps_w;

  always_comb begin
    dx_w    = (C+1)'(ld_q.x_end) - (C+1)'(ld_q.x_start);
    dy_w    = (C+1)'(ld_q.y_end) - (C+1)'(ld_q.y_start);
    nx_w    = dx_w[C] ? (~dx_w + 1'b1) : dx_w;
    ny_w    = dy_w[C] ? (~dy_w + 1'b1) : dy_w;
    // a delta of two coordinates never exceeds the coordinate magnitude range
    mag_x_w = nx_w[C-1:0];
    mag_y_w = ny_w[C-1:0];
    steps_w = (mag_x_w >= mag_y_w) ? mag_x_w : mag_y_w;
  end

  // ---------------------------------------------------------------------------
  // divider: numerator (|d| << FRAC_BITS) + steps/2, quotient at most 2^FRAC_BITS,
  // so the top bits already sit below the divisor and only Q_BITS steps remain
  // ---------------------------------------------------------------------------
  logic [NUM_BITS-1:0] num_w;
  logic [C:0]          trial_w, diff_w;
  logic                ge_w;

  always_comb begin
    num_w = {1'b0, (uw.op == OP_DIVY_INIT) ? mag_y_q : mag_x_q, {FRAC_BITS{1'b0}}}
          + NUM_BITS'(steps_q[C-1:1]);
    trial_w = {rem_q, qn_q[Q_BITS-1]};
    diff_w  = trial_w - {1'b0, steps_q};
    ge_w    = trial_w >= {1'b0, steps_q};

    rem_d = rem_q;
    qn_d  = qn_q;
    case (uw.op)
      OP_DIVX_INIT, OP_DIVY_INIT: begin
        rem_d = num_w[NUM_BITS-1:Q_BITS];
        qn_d  = num_w[Q_BITS-1:0];
      end
      OP_DIV_STEP: begin
        rem_d = ge_w ? diff_w[C-1:0] : trial_w[C-1:0];
        qn_d  = {qn_q[Q_BITS-2:0], ge_w};
      end
      default: begin
      end
    endcase
  end

  // signed increment from the finished quotient
  logic signed [INC_BITS-1:0] inc_mag_w;
  assign inc_mag_w = INC_BITS'(qn_q);

  // ---------------------------------------------------------------------------
  // pixel from the running position, truncated toward zero, with clip test
  // ---------------------------------------------------------------------------
  function automatic logic signed [PX_BITS-1:0] trunc_pos(input logic signed [POS_BITS-1:0] p);
    logic [POS_BITS-1:0] pm;
    logic [C:0]          tm;
    pm = p[POS_BITS-1] ? (~p + 1'b1) : p;
    tm = pm[POS_BITS-1:FRAC_BITS];
    return p[POS_BITS-1] ? -PX_BITS'(tm) : PX_BITS'(tm);
  endfunction

  logic signed [PX_BITS-1:0] px_w, py_w;
  logic                      vis_w;

  always_comb begin
    px_w  = trunc_pos(pos_x_q);
    py_w  = trunc_pos(pos_y_q);
    // zero size registers leave nothing below them, so every pixel is clipped
    vis_w = !px_w[PX_BITS-1] && !py_w[PX_BITS-1]
         && (px_w < $signed(PX_BITS'(width_q)))
         && (py_w < $signed(PX_BITS'(height_q)));
  end

  // ---------------------------------------------------------------------------
  // sequencer: jump on the control word's condition, else fall through
  // ---------------------------------------------------------------------------
  always_comb begin
    unique case (uw.cond)
      COND_NEVER:   cond_hit = 1'b0;
      COND_ALWAYS:  cond_hit = 1'b1;
      COND_NO_LOAD: cond_hit = !load_fire;
      COND_ZERO:    cond_hit = (steps_w == '0);
      COND_ITER:    cond_hit = (cnt_q != CNT_BITS'(1));
      default:      cond_hit = 1'b1;
    endcase
    pc_d = cond_hit ? uw.target : pc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PC_WAIT;
      width_q     <= WIDTH_RESET;
      height_q    <= HEIGHT_RESET;
      left_q      <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      pc_q <= pc_d;

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_IDX_WIDTH:  width_q  <= cfg_data_i;
          CFG_IDX_HEIGHT: height_q <= cfg_data_i;
          default: begin
          end
        endcase
      end

      // output register drains on take, refills on an emitted pixel
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (emit) begin
        left_q <= left_q - 1'b1;
      end else if (uw.op == OP_SETUP) begin
        left_q <= LEFT_BITS'(steps_w);
      end

      if (uw.op == OP_DIVX_INIT || uw.op == OP_DIVY_INIT) begin
        cnt_q <= CNT_BITS'(ITERS);
      end else if (uw.op == OP_DIV_STEP) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      inc_x_q <= '0;
      inc_y_q <= '0;
      color_q <= '0;
    end else begin
      if (emit) begin
        pos_x_q <= pos_x_q + POS_BITS'(inc_x_q);
        pos_y_q <= pos_y_q + POS_BITS'(inc_y_q);
      end else if (uw.op == OP_SETUP) begin
        pos_x_q <= POS_BITS'(ld_q.x_start) <<< FRAC_BITS;
        pos_y_q <= POS_BITS'(ld_q.y_start) <<< FRAC_BITS;
      end

      if (uw.op == OP_SETUP) begin
        color_q <= ld_q.line_color;
        inc_x_q <= '0;
        inc_y_q <= '0;
      end else if (uw.op == OP_STORE_X) begin
        inc_x_q <= neg_x_q ? -inc_mag_w : inc_mag_w;
      end else if (uw.op == OP_STORE_Y) begin
        inc_y_q <= neg_y_q ? -inc_mag_w : inc_mag_w;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_fire) begin
      ld_q <= in_word_i;
    end
    if (uw.op == OP_SETUP) begin
      mag_x_q <= mag_x_w;
      mag_y_q <= mag_y_w;
      neg_x_q <= dx_w[C];
      neg_y_q <= dy_w[C];
      steps_q <= steps_w;
    end
    rem_q <= rem_d;
    qn_q  <= qn_d;
    if (emit) begin
      out_q.pixel_x     <= px_w[C-1:0];
      out_q.pixel_y     <= py_w[C-1:0];
      out_q.pixel_color <= color_q;
      out_q.on_screen   <= vis_w;
      out_q.last        <= (left_q == LEFT_BITS'(1));
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // divide steps only run for a line of nonzero length
  a_div_has_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.op == OP_DIV_STEP) |-> (left_q != '0) && (steps_q != '0))
    else $error("divide step without an active line");

  // restoring remainder stays below the divisor
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.op == OP_DIV_STEP) |-> (rem_q < steps_q))
    else $error("divider remainder out of range");

  // the rounded increment never exceeds one pixel
  a_inc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.op == OP_STORE_X || uw.op == OP_STORE_Y) |-> (qn_q <= (Q_BITS'(1) << FRAC_BITS)))
    else $error("increment magnitude above one");

  // the final pixel of a line leaves no line active
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && left_q == LEFT_BITS'(1)) |=> (left_q == '0) && out_q.last)
    else $error("line not closed after last pixel");

endmodule

@@ verif/dda_lr_checker.sv @@
// scoreboard for the dda line rasterizer: predicts pixel words and compares them
module dda_lr_checker
  import dda_lr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  in_word_t                in_word_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  out_word_t               out_word_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [CFG_BITS-1:0]     cfg_data_i,
  output int                      fail_count_o,
  output int                      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POS_W  = COORD_BITS + FRAC_BITS + 1;
  localparam int INC_W  = FRAC_BITS + 2;
  localparam int LEFT_W = COORD_BITS + 1;

  logic signed [POS_W-1:0] pos_x_q, pos_y_q;
  logic signed [INC_W-1:0] inc_x_q, inc_y_q;
  logic [LEFT_W-1:0]       left_q;
  logic [COLOR_BITS-1:0]   color_q;
  logic [CFG_BITS-1:0]     width_q, height_q;
  out_word_t               pixels_due [$];
  out_word_t               due_pixel;
  int                      errors = 0;

  // rounded to nearest, ties away from zero
  function automatic logic signed [INC_W-1:0] slope(input longint delta, input longint steps);
    longint q;
    q = (((delta < 0 ? -delta : delta) << FRAC_BITS) + steps / 2) / steps;
    return INC_W'(delta < 0 ? -q : q);
  endfunction

  function automatic longint trunc_coord(input logic signed [POS_W-1:0] p);
    longint v, m;
    v = p;
    m = (v < 0 ? -v : v) >> FRAC_BITS;
    return v < 0 ? -m : m;
  endfunction

  task automatic rasterize_word(input in_word_t w);
    longint xs, ys, dx, dy, adx, ady, steps, px, py;
    out_word_t pix;
    if (w.cmd == CMD_LOAD) begin
      xs = $signed(w.x_start);
      ys = $signed(w.y_start);
      dx = longint'($signed(w.x_end)) - xs;
      dy = longint'($signed(w.y_end)) - ys;
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      steps = adx >= ady ? adx : ady;
      color_q = w.line_color;
      pos_x_q = POS_W'(xs <<< FRAC_BITS);
      pos_y_q = POS_W'(ys <<< FRAC_BITS);
      left_q = LEFT_W'(steps);
      inc_x_q = (steps != 0) ? slope(dx, steps) : '0;
      inc_y_q = (steps != 0) ? slope(dy, steps) : '0;
    end else if (left_q != '0) begin
      px = trunc_coord(pos_x_q);
      py = trunc_coord(pos_y_q);
      pix.pixel_x = COORD_BITS'(px);
      pix.pixel_y = COORD_BITS'(py);
      pix.pixel_color = color_q;
      pix.on_screen = px >= 0 && py >= 0 &&
                      px < longint'(width_q) && py < longint'(height_q);
      pix.last = (left_q == LEFT_W'(1));
      pixels_due.push_back(pix);
      pos_x_q = pos_x_q + inc_x_q;
      pos_y_q = pos_y_q + inc_y_q;
      left_q = left_q - 1'b1;
    end
  endtask

  task automatic compare_field(input string name, input logic signed [COLOR_BITS:0] want,
                               input logic signed [COLOR_BITS:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q = '0;
      pos_y_q = '0;
      inc_x_q = '0;
      inc_y_q = '0;
      left_q = '0;
      color_q = '0;
      width_q = WIDTH_RESET;
      height_q = HEIGHT_RESET;
      pixels_due.delete();
    end else begin
      // a word leaving now was predicted at an earlier edge
      if (out_valid_i && out_ready_i) begin
        if (pixels_due.size() == 0) begin
          $error("pixel word with none expected: x %0d y %0d",
                 out_word_i.pixel_x, out_word_i.pixel_y);
          errors++;
        end else begin
          due_pixel = pixels_due.pop_front();
          compare_field("pixel_x", due_pixel.pixel_x, out_word_i.pixel_x);
          compare_field("pixel_y", due_pixel.pixel_y, out_word_i.pixel_y);
          compare_field("pixel_color", due_pixel.pixel_color, out_word_i.pixel_color);
          compare_field("on_screen", due_pixel.on_screen, out_word_i.on_screen);
          compare_field("last", due_pixel.last, out_word_i.last);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_IDX_WIDTH:  width_q = cfg_data_i;
          CFG_IDX_HEIGHT: height_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        rasterize_word(in_word_i);
      end
    end
    pending_o <= pixels_due.size();
    fail_count_o <= errors;
  end

endmodule

@@ verif/dda_line_rasterizer_unit_tb.sv @@
// testbench top for the dda line rasterizer: stimulus, stalls, screen settings and verdict
module dda_line_rasterizer_unit_tb
  import dda_lr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // settling covers a full load sequence of the sequencer, plus some margin
  localparam int SETTLE_CYCLES = 2 * FRAC_BITS_DEF + 7 + 16;
  localparam int PHASE_WORDS   = 160;
  localparam int NUM_PHASES    = 7;
  localparam int MAX_GAP       = 13;
  // first index past the defined registers, writes there must be dropped
  localparam int CFG_IDX_SPARE = int'(CFG_IDX_HEIGHT) + 1;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  in_word_t                in_word = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  out_word_t               out_word;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0]     cfg_data = '0;
  int                      fail_count;
  int                      pending;
  bit                      in_burst = 1'b0;

  dda_line_rasterizer_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  dda_lr_checker #(
    .FRAC_BITS (FRAC_BITS_DEF)
  ) checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_word_i   (out_word),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 100 MHz clock
  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs; far above the slowest legal run
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // pixel sink: random stall before each word, with stretches of full throughput
  initial begin : pixel_sink
    int  stall;
    bit  eager;
    eager = 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) begin
        eager = !eager;
      end
      stall = eager ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      // hold ready until a word actually leaves
      do @(posedge clk); while (!out_valid);
    end
  end

  // present one input word after a random gap and hold it until taken;
  // valid stays high across back-to-back words
  task automatic send_word(input in_word_t w);
    int gap;
    if ($urandom_range(0, 47) == 0) begin
      in_burst = !in_burst;
    end
    gap = in_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid, wait for every predicted pixel to drain, then let the sequencer finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input int idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_BITS'(idx);
    cfg_data <= CFG_BITS'(value);
    do @(posedge clk); while (!cfg_ready);
  endtask

  // width, a stray write to an unused index, then height
  task automatic program_screen(input int w, input int h);
    write_reg(int'(CFG_IDX_WIDTH), w);
    write_reg($urandom_range(CFG_IDX_SPARE, (1 << CFG_IDX_BITS) - 1), $urandom_range(0, 4095));
    write_reg(int'(CFG_IDX_HEIGHT), h);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_word_t line_word(input int xs, input int ys, input int xe,
                                         input int ye, input logic [COLOR_BITS-1:0] color);
    in_word_t w;
    w.cmd = CMD_LOAD;
    w.x_start = COORD_BITS'(xs);
    w.y_start = COORD_BITS'(ys);
    w.x_end = COORD_BITS'(xe);
    w.y_end = COORD_BITS'(ye);
    w.line_color = color;
    return w;
  endfunction

  // step word with junk in the unused fields
  function automatic in_word_t step_word();
    in_word_t w;
    w.cmd = CMD_STEP;
    w.x_start = COORD_BITS'($urandom);
    w.y_start = COORD_BITS'($urandom);
    w.x_end = COORD_BITS'($urandom);
    w.y_end = COORD_BITS'($urandom);
    w.line_color = $urandom;
    return w;
  endfunction

  function automatic int clamp_coord(input int v);
    if (v > 2047) return 2047;
    if (v < -2048) return -2048;
    return v;
  endfunction

  // random line whose deltas stay within +-reach; zero reach gives a point
  function automatic in_word_t random_line(input int reach);
    int xs, ys, dx, dy;
    if ($urandom_range(0, 1) == 1) begin
      xs = $urandom_range(0, 4095) - 2048;
      ys = $urandom_range(0, 4095) - 2048;
    end else begin
      // hug the usual screen area so clipping flips often
      xs = $urandom_range(0, 840) - 16;
      ys = $urandom_range(0, 640) - 16;
    end
    dx = $urandom_range(0, 2 * reach) - reach;
    dy = $urandom_range(0, 2 * reach) - reach;
    case ($urandom_range(0, 9))
      0: dy = 0;
      1: dx = 0;
      2: dy = ($urandom_range(0, 1) == 1) ? dx : -dx;
      default: ;
    endcase
    return line_word(xs, ys, clamp_coord(xs + dx), clamp_coord(ys + dy), $urandom);
  endfunction

  function automatic int line_span(input in_word_t w);
    int ax, ay;
    ax = $signed(w.x_end) - $signed(w.x_start);
    ay = $signed(w.y_end) - $signed(w.y_start);
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    return ax >= ay ? ax : ay;
  endfunction

  task automatic run_line(input in_word_t w, input int steps);
    send_word(w);
    repeat (steps) send_word(step_word());
  endtask

  initial begin : stimulus
    in_word_t w;
    int       phase_w [NUM_PHASES];
    int       phase_h [NUM_PHASES];
    int       len, n_steps, pick, reach, n;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset screen of 800 x 600
    // step with nothing loaded
    send_word(step_word());
    // zero-length line, the step after it must stay silent
    run_line(line_word(10, 10, 10, 10, 32'h1234_5678), 1);
    // full diagonal corner to corner, unit increments on both axes
    run_line(line_word(-2048, -2048, 2047, 2047, 32'hFFFF_FFFF), 2);
    // reload mid-line with the opposite diagonal and a zero color
    run_line(line_word(2047, -2048, -2048, 2047, 32'h0000_0000), 2);
    // shallow line, one extra step past its end
    run_line(line_word(0, 0, 5, -3, 32'h5A5A_A5A5), 6);
    // steep line crossing the bottom right screen corner
    run_line(line_word(798, 598, 801, 602, 32'hA5A5_5A5A), 4);
    // crossing zero, truncation toward zero on both signs
    run_line(line_word(1, 1, -2, -3, 32'h8000_0001), 4);
    settle();

    // screen settings per phase: reset values first, then the extremes,
    // zero sizes and random values
    phase_w = '{800, 1, 2048, 0, $urandom_range(0, 4095), 4095, $urandom_range(1, 2048)};
    phase_h = '{600, 1, 2048, $urandom_range(0, 4095), 0, 4095, $urandom_range(1, 2048)};

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        program_screen(phase_w[p], phase_h[p]);
      end
      n = 0;
      while (n < PHASE_WORDS) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          // stray step, usually with no line active
          send_word(step_word());
        end else if (pick < 8) begin
          // point load followed by a step that must give nothing
          run_line(random_line(0), 1);
          n++;
        end else begin
          reach = (pick < 14) ? 4096 : ((pick < 24) ? 80 : 24);
          w = random_line(reach);
          len = line_span(w);
          if (reach == 4096) begin
            // long lines get cut off by the next load
            n_steps = $urandom_range(1, 24);
          end else if ($urandom_range(0, 9) == 0) begin
            n_steps = $urandom_range(0, len);
          end else begin
            // mostly complete, now and then one step past the end
            n_steps = len + (($urandom_range(0, 3) == 0) ? 1 : 0);
          end
          run_line(w, n_steps);
          n += 1 + n_steps;
        end
      end
      settle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
